// ----- rtl/core/b64enc_pkg.sv -----
package b64enc_pkg;

  // ASCII code of the '=' padding character.
  localparam logic [6:0] PadChar = 7'd61;

  // Number of entries in the group queue between front and back.
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueueAw    = $clog2(QueueDepth);

  // One group of up to three bytes, left aligned, with its padding count.
  typedef struct packed {
    logic [23:0] data;
    logic [1:0]  pad_cnt;
    logic        fin;
  } job_t;

  // Map a 6-bit group onto the standard alphabet.
  function automatic logic [6:0] sym(input logic [5:0] v);
    logic [6:0] r;
    if (v < 6'd26) begin
      r = 7'd65 + {1'b0, v};
    end else if (v < 6'd52) begin
      r = 7'd71 + {1'b0, v};
    end else if (v < 6'd62) begin
      r = {1'b0, v} - 7'd4;
    end else if (v == 6'd62) begin
      r = 7'd43;
    end else begin
      r = 7'd47;
    end
    return r;
  endfunction

endpackage

// ----- rtl/core/b64enc_front.sv -----
module b64enc_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [7:0]        data_byte_i,
  input  logic              final_byte_i,
  output logic              push_o,
  output b64enc_pkg::job_t  job_o,
  input  logic              push_ready_i
);

  logic [15:0] pend_q, pend_d;
  logic [1:0]  cnt_q, cnt_d;
  logic        closes;
  logic        accept;

  // A word closes a group when it is the third byte or the final one.
  assign closes     = final_byte_i || (cnt_q >= 2'd2);
  assign in_ready_o = !closes || push_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign push_o     = accept && closes;

  // Build the left-aligned group and its padding count.
  always_comb begin
    job_o.fin = final_byte_i;
    if (cnt_q >= 2'd2) begin
      job_o.data    = {pend_q, data_byte_i};
      job_o.pad_cnt = 2'd0;
    end else if (cnt_q == 2'd1) begin
      job_o.data    = {pend_q[7:0], data_byte_i, 8'd0};
      job_o.pad_cnt = 2'd1;
    end else begin
      job_o.data    = {data_byte_i, 16'd0};
      job_o.pad_cnt = 2'd2;
    end
  end

  // Pending bytes collect until a group closes.
  always_comb begin
    pend_d = pend_q;
    cnt_d  = cnt_q;
    if (accept) begin
      if (closes) begin
        pend_d = '0;
        cnt_d  = '0;
      end else begin
        pend_d = {pend_q[7:0], data_byte_i};
        cnt_d  = cnt_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
      cnt_q  <= '0;
    end else begin
      pend_q <= pend_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule

// ----- rtl/core/b64enc_fifo.sv -----
module b64enc_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  b64enc_pkg::job_t  push_job_i,
  output logic              push_ready_o,
  input  logic              pop_i,
  output b64enc_pkg::job_t  pop_job_o,
  output logic              pop_valid_o
);

  localparam int unsigned Aw = b64enc_pkg::QueueAw;

  b64enc_pkg::job_t        mem_q [b64enc_pkg::QueueDepth];
  logic [Aw-1:0]           wr_q, wr_d, rd_q, rd_d;
  logic [Aw:0]             cnt_q, cnt_d;
  logic                    do_push, do_pop;

  assign push_ready_o = cnt_q < (Aw+1)'(b64enc_pkg::QueueDepth);
  assign pop_valid_o  = cnt_q != '0;
  assign pop_job_o    = mem_q[rd_q];
  assign do_push      = push_i && push_ready_o;
  assign do_pop       = pop_i && pop_valid_o;

  // Pointer and fill count update.
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == Aw'(b64enc_pkg::QueueDepth - 1)) ? '0 : wr_q + Aw'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == Aw'(b64enc_pkg::QueueDepth - 1)) ? '0 : rd_q + Aw'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + (Aw+1)'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - (Aw+1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Queue storage holds payload only.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_job_i;
    end
  end

endmodule

// ----- rtl/core/b64enc_back.sv -----
module b64enc_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              job_valid_i,
  input  b64enc_pkg::job_t  job_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [6:0]        out_char_o,
  output logic              last_char_o
);

  logic [1:0] idx_q, idx_d;
  logic       vld_q, vld_d;
  logic [6:0] char_q, char_d;
  logic       last_q, last_d;
  logic       load;
  logic       step;
  logic [5:0] grp;
  logic       is_pad;

  // The output register takes a new word when it is empty or being drained.
  assign load = !vld_q || out_ready_i;
  assign step = load && job_valid_i;
  assign pop_o = step && (idx_q == 2'd3);

  // Select the current 6-bit group, or padding for the tail positions.
  always_comb begin
    case (idx_q)
      2'd0:    grp = job_i.data[23:18];
      2'd1:    grp = job_i.data[17:12];
      2'd2:    grp = job_i.data[11:6];
      default: grp = job_i.data[5:0];
    endcase
  end
  assign is_pad = ({1'b0, idx_q} + {1'b0, job_i.pad_cnt}) >= 3'd4;

  always_comb begin
    idx_d  = idx_q;
    vld_d  = vld_q;
    char_d = char_q;
    last_d = last_q;
    if (load) begin
      vld_d = job_valid_i;
      if (job_valid_i) begin
        char_d = is_pad ? b64enc_pkg::PadChar : b64enc_pkg::sym(grp);
        last_d = job_i.fin && (idx_q == 2'd3);
        idx_d  = idx_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
      vld_q <= 1'b0;
    end else begin
      idx_q <= idx_d;
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    char_q <= char_d;
    last_q <= last_d;
  end

  assign out_valid_o = vld_q;
  assign out_char_o  = char_q;
  assign last_char_o = last_q;

endmodule

// ----- rtl/core/base64_stream_encoder_unit.sv -----
// A group is held in the queue, and each character is registered at the output.
// Throughput: one character per cycle from the back end while out_ready_i is high and a
// group is queued; a group of three bytes gives four characters.
// A two-entry group queue lets the front take bytes while the back drains characters.
// Reset (rst_ni, asynchronous, active low) clears pending bytes, the queue and the output.
module base64_stream_encoder_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] data_byte_i,
  input  logic       final_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [6:0] out_char_o,
  output logic       last_char_o
);

  logic             push;
  logic             push_ready;
  logic             pop;
  logic             pop_valid;
  b64enc_pkg::job_t push_job;
  b64enc_pkg::job_t pop_job;

  // Front end collects bytes into groups.
  b64enc_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .data_byte_i  (data_byte_i),
    .final_byte_i (final_byte_i),
    .push_o       (push),
    .job_o        (push_job),
    .push_ready_i (push_ready)
  );

  // Group queue between the two halves.
  b64enc_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_job_i   (push_job),
    .push_ready_o (push_ready),
    .pop_i        (pop),
    .pop_job_o    (pop_job),
    .pop_valid_o  (pop_valid)
  );

  // Back end emits four characters per group.
  b64enc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (pop_valid),
    .job_i       (pop_job),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_char_o  (out_char_o),
    .last_char_o (last_char_o)
  );

endmodule
